FILE: hdl/tlc_pkg.sv
// tlc_pkg: sizes, line and row types, config codes and per-level cache functions
// used by the two-level cache model core. No dependencies.
package tlc_pkg;

    localparam int BLOCK_LOG   = 4;
    localparam int L1_SIZE_LOG = 12;
    localparam int L1_WAYS_LOG = 1;
    localparam int L2_SIZE_LOG = 15;
    localparam int L2_WAYS_LOG = 2;

    localparam int L1_SET_LOG = (L1_SIZE_LOG - BLOCK_LOG - L1_WAYS_LOG) > 0 ?
                                (L1_SIZE_LOG - BLOCK_LOG - L1_WAYS_LOG) : 0;
    localparam int L2_SET_LOG = (L2_SIZE_LOG - BLOCK_LOG - L2_WAYS_LOG) > 0 ?
                                (L2_SIZE_LOG - BLOCK_LOG - L2_WAYS_LOG) : 0;
    localparam int L1_SET_W  = L1_SET_LOG > 0 ? L1_SET_LOG : 1;
    localparam int L2_SET_W  = L2_SET_LOG > 0 ? L2_SET_LOG : 1;
    localparam int L1_TAG_W  = 32 - BLOCK_LOG - L1_SET_LOG;
    localparam int L2_TAG_W  = 32 - BLOCK_LOG - L2_SET_LOG;
    localparam int L1_WAYS   = 1 << L1_WAYS_LOG;
    localparam int L2_WAYS   = 1 << L2_WAYS_LOG;
    localparam int L1_WAY_W  = L1_WAYS_LOG > 0 ? L1_WAYS_LOG : 1;
    localparam int L2_WAY_W  = L2_WAYS_LOG > 0 ? L2_WAYS_LOG : 1;
    localparam int L1_ROWS   = 1 << L1_SET_W;
    localparam int L2_ROWS   = 1 << L2_SET_W;
    localparam int CLR_W     = L1_SET_W > L2_SET_W ? L1_SET_W : L2_SET_W;
    localparam int CLR_ROWS  = 1 << CLR_W;
    localparam logic [31:0] L1_SET_MASK = 32'((64'd1 << L1_SET_LOG) - 64'd1);
    localparam logic [31:0] L2_SET_MASK = 32'((64'd1 << L2_SET_LOG) - 64'd1);

    localparam int CNT_W   = 32;
    localparam int CYC_W   = 48;
    localparam int LAT_W   = 10;
    localparam int ACYC_W  = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_WALLOC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WALLOC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_LAT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_LAT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LAT   = 3'd4;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [L1_WAY_W-1:0] age;
        logic [L1_TAG_W-1:0] tag;
    } t_l1_line;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [L2_WAY_W-1:0] age;
        logic [L2_TAG_W-1:0] tag;
    } t_l2_line;

    typedef t_l1_line [L1_WAYS-1:0] t_l1_row;
    typedef t_l2_line [L2_WAYS-1:0] t_l2_row;

    typedef struct packed {
        logic        hit;
        logic        removed;
        logic        wback;
        logic [31:0] vaddr;
        t_l1_row     row;
    } t_l1_res;

    typedef struct packed {
        logic        hit;
        logic        removed;
        logic        wback;
        logic [31:0] vaddr;
        t_l2_row     row;
    } t_l2_res;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_FIX_RD,
        S_FIX,
        S_DONE
    } t_state;

    function automatic logic [L1_SET_W-1:0] l1_set(logic [31:0] a);
        return L1_SET_W'((a >> BLOCK_LOG) & L1_SET_MASK);
    endfunction

    function automatic logic [L2_SET_W-1:0] l2_set(logic [31:0] a);
        return L2_SET_W'((a >> BLOCK_LOG) & L2_SET_MASK);
    endfunction

    function automatic logic [L1_TAG_W-1:0] l1_tag(logic [31:0] a);
        return L1_TAG_W'(a >> (BLOCK_LOG + L1_SET_LOG));
    endfunction

    function automatic logic [L2_TAG_W-1:0] l2_tag(logic [31:0] a);
        return L2_TAG_W'(a >> (BLOCK_LOG + L2_SET_LOG));
    endfunction

    // accessed line goes to the top age, lines above its old age step down
    function automatic t_l1_row l1_touch(t_l1_row row, logic [L1_TAG_W-1:0] tag);
        t_l1_row             r;
        logic                found;
        logic [L1_WAY_W-1:0] hw;
        logic [L1_WAY_W-1:0] cur;
        r = row;
        found = 1'b0;
        hw = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (!found && row[w].valid && row[w].tag == tag) begin
                found = 1'b1;
                hw = L1_WAY_W'(w);
            end
        end
        if (found) begin
            cur = row[hw].age;
            for (int w = 0; w < L1_WAYS; w++) begin
                if (L1_WAY_W'(w) != hw && row[w].age > cur)
                    r[w].age = row[w].age - 1'b1;
            end
            r[hw].age = L1_WAY_W'(L1_WAYS - 1);
        end
        return r;
    endfunction

    function automatic t_l2_row l2_touch(t_l2_row row, logic [L2_TAG_W-1:0] tag);
        t_l2_row             r;
        logic                found;
        logic [L2_WAY_W-1:0] hw;
        logic [L2_WAY_W-1:0] cur;
        r = row;
        found = 1'b0;
        hw = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!found && row[w].valid && row[w].tag == tag) begin
                found = 1'b1;
                hw = L2_WAY_W'(w);
            end
        end
        if (found) begin
            cur = row[hw].age;
            for (int w = 0; w < L2_WAYS; w++) begin
                if (L2_WAY_W'(w) != hw && row[w].age > cur)
                    r[w].age = row[w].age - 1'b1;
            end
            r[hw].age = L2_WAY_W'(L2_WAYS - 1);
        end
        return r;
    endfunction

    // invalidate the valid line holding this tag, if any
    function automatic t_l1_row l1_drop(t_l1_row row, logic [L1_TAG_W-1:0] tag);
        t_l1_row r;
        logic    found;
        r = row;
        found = 1'b0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (!found && row[w].valid && row[w].tag == tag) begin
                found = 1'b1;
                r[w].valid = 1'b0;
                r[w].age = '0;
            end
        end
        return r;
    endfunction

    function automatic t_l1_res l1_access(t_l1_row row, logic [31:0] a, logic wr,
                                          logic alloc);
        t_l1_res             res;
        logic [L1_SET_W-1:0] set;
        logic [L1_TAG_W-1:0] tag;
        logic                found;
        logic                vfound;
        logic [L1_WAY_W-1:0] hw;
        logic [L1_WAY_W-1:0] vw;
        t_l1_row             r;
        set = l1_set(a);
        tag = l1_tag(a);
        found = 1'b0;
        vfound = 1'b0;
        hw = '0;
        vw = '0;
        for (int w = 0; w < L1_WAYS; w++) begin
            if (!found && row[w].valid && row[w].tag == tag) begin
                found = 1'b1;
                hw = L1_WAY_W'(w);
            end
            if (!vfound && (!row[w].valid || row[w].age == '0)) begin
                vfound = 1'b1;
                vw = L1_WAY_W'(w);
            end
        end
        res.hit = found;
        res.removed = 1'b0;
        res.wback = 1'b0;
        res.vaddr = '0;
        res.row = row;
        if (found) begin
            r = l1_touch(row, tag);
            if (wr)
                r[hw].dirty = 1'b1;
            res.row = r;
        end else if (!wr || alloc) begin
            res.removed = row[vw].valid;
            res.wback = row[vw].valid & row[vw].dirty;
            if (row[vw].valid)
                res.vaddr = (32'(row[vw].tag) << (BLOCK_LOG + L1_SET_LOG))
                          | (32'(set) << BLOCK_LOG);
            r = row;
            r[vw].tag = tag;
            r[vw].valid = 1'b1;
            r[vw].dirty = 1'b0;
            r = l1_touch(r, tag);
            r[vw].dirty = wr;
            res.row = r;
        end
        return res;
    endfunction

    function automatic t_l2_res l2_access(t_l2_row row, logic [31:0] a, logic wr,
                                          logic alloc);
        t_l2_res             res;
        logic [L2_SET_W-1:0] set;
        logic [L2_TAG_W-1:0] tag;
        logic                found;
        logic                vfound;
        logic [L2_WAY_W-1:0] hw;
        logic [L2_WAY_W-1:0] vw;
        t_l2_row             r;
        set = l2_set(a);
        tag = l2_tag(a);
        found = 1'b0;
        vfound = 1'b0;
        hw = '0;
        vw = '0;
        for (int w = 0; w < L2_WAYS; w++) begin
            if (!found && row[w].valid && row[w].tag == tag) begin
                found = 1'b1;
                hw = L2_WAY_W'(w);
            end
            if (!vfound && (!row[w].valid || row[w].age == '0)) begin
                vfound = 1'b1;
                vw = L2_WAY_W'(w);
            end
        end
        res.hit = found;
        res.removed = 1'b0;
        res.wback = 1'b0;
        res.vaddr = '0;
        res.row = row;
        if (found) begin
            r = l2_touch(row, tag);
            if (wr)
                r[hw].dirty = 1'b1;
            res.row = r;
        end else if (!wr || alloc) begin
            res.removed = row[vw].valid;
            res.wback = row[vw].valid & row[vw].dirty;
            if (row[vw].valid)
                res.vaddr = (32'(row[vw].tag) << (BLOCK_LOG + L2_SET_LOG))
                          | (32'(set) << BLOCK_LOG);
            r = row;
            r[vw].tag = tag;
            r[vw].valid = 1'b1;
            r[vw].dirty = 1'b0;
            r = l2_touch(r, tag);
            r[vw].dirty = wr;
            res.row = r;
        end
        return res;
    endfunction

endpackage

FILE: hdl/two_level_cache_lru_model_core.sv
// two_level_cache_lru_model_core: L1/L2 set-associative cache state and statistics.
// Depends on tlc_pkg for sizes, row types and the per-level access functions.
//
// Usage:
//   Input channel i_valid/o_stall carries one access (i_func, i_address).
//   Output channel o_valid/i_stall returns hit flags, the cycles charged and
//   the running counters after that access. Config port i_cfg_valid/o_cfg_ready
//   writes one register per item by index; write only while the block is idle.
// Timing:
//   Each level keeps one row per set (all ways) in a one-read, one-write RAM.
//   An item goes from acceptance through S_LOOKUP and S_DONE to o_valid, or through
//   S_LOOKUP, S_FIX_RD, S_FIX and S_DONE when an L2 eviction invalidates an L1
//   line or a dirty L1 victim refreshes its L2 age; those need a second read of the
//   victim's set. One item is in flight at a time: a new one is taken only in S_IDLE.
// Reset:
//   Counters and config registers take their reset values, then a clearing
//   pass writes every row of both RAMs invalid, stepping through 2**max(set bits)
//   row indices (512 with the default sizes); o_stall stays high during the pass.
// Stall:
//   A finished result waits in the output register; a new item is taken
//   meanwhile, and its result waits in the last step until the register frees.
module two_level_cache_lru_model_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_l1_hit,
    output logic        o_l2_looked_up,
    output logic        o_l2_hit,
    output logic [11:0] o_access_cycles,
    output logic [31:0] o_l1_access_count,
    output logic [31:0] o_l1_miss_count,
    output logic [31:0] o_l2_access_count,
    output logic [31:0] o_l2_miss_count,
    output logic [47:0] o_cycle_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    tlc_pkg::t_state r_state, n_state;

    tlc_pkg::t_l1_row r_l1_mem [tlc_pkg::L1_ROWS];
    tlc_pkg::t_l2_row r_l2_mem [tlc_pkg::L2_ROWS];
    tlc_pkg::t_l1_row r_l1_rd;
    tlc_pkg::t_l2_row r_l2_rd;

    logic                          l1_we, l2_we;
    logic [tlc_pkg::L1_SET_W-1:0]  l1_wa, l1_ra;
    logic [tlc_pkg::L2_SET_W-1:0]  l2_wa, l2_ra;
    tlc_pkg::t_l1_row              l1_wd;
    tlc_pkg::t_l2_row              l2_wd;

    logic [tlc_pkg::CLR_W-1:0] r_clr;
    logic        r_func;
    logic [31:0] r_addr;
    logic        r_l1_hit, r_l2_hit;
    logic        r_need_drop, r_need_touch;
    logic [31:0] r_v1, r_v2;

    logic                      r_l1_walloc, r_l2_walloc;
    logic [tlc_pkg::LAT_W-1:0] r_l1_lat, r_l2_lat, r_mem_lat;

    logic [tlc_pkg::CNT_W-1:0] r_l1_acc, r_l1_miss, r_l2_acc, r_l2_miss;
    logic [tlc_pkg::CYC_W-1:0] r_cyc_sum;

    logic                       r_o_vld;
    logic                       r_o_l1_hit, r_o_looked, r_o_l2_hit;
    logic [tlc_pkg::ACYC_W-1:0] r_o_cyc;

    tlc_pkg::t_l1_res l1_res;
    tlc_pkg::t_l2_res l2_res;
    logic             accept, load;
    logic [tlc_pkg::ACYC_W-1:0] cyc;
    logic [tlc_pkg::CYC_W:0]    cyc_sum_wide;

    assign accept = i_valid && (r_state == tlc_pkg::S_IDLE);
    assign load   = (r_state == tlc_pkg::S_DONE) && (!r_o_vld || !i_stall);

    assign l1_res = tlc_pkg::l1_access(r_l1_rd, r_addr, r_func, r_l1_walloc);
    assign l2_res = tlc_pkg::l2_access(r_l2_rd, r_addr, r_func, r_l2_walloc);

    always_comb begin
        cyc = tlc_pkg::ACYC_W'(r_l1_lat);
        if (!r_l1_hit) begin
            cyc = cyc + tlc_pkg::ACYC_W'(r_l2_lat);
            if (!r_l2_hit)
                cyc = cyc + tlc_pkg::ACYC_W'(r_mem_lat);
        end
        cyc_sum_wide = {1'b0, r_cyc_sum} + (tlc_pkg::CYC_W + 1)'(cyc);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlc_pkg::S_CLEAR: begin
                if (r_clr == tlc_pkg::CLR_W'(tlc_pkg::CLR_ROWS - 1))
                    n_state = tlc_pkg::S_IDLE;
            end
            tlc_pkg::S_IDLE: begin
                if (i_valid)
                    n_state = tlc_pkg::S_LOOKUP;
            end
            tlc_pkg::S_LOOKUP: begin
                if (!l1_res.hit && ((!l2_res.hit && l2_res.removed) || l1_res.wback))
                    n_state = tlc_pkg::S_FIX_RD;
                else
                    n_state = tlc_pkg::S_DONE;
            end
            tlc_pkg::S_FIX_RD: n_state = tlc_pkg::S_FIX;
            tlc_pkg::S_FIX:    n_state = tlc_pkg::S_DONE;
            tlc_pkg::S_DONE: begin
                if (load)
                    n_state = tlc_pkg::S_IDLE;
            end
            default: n_state = tlc_pkg::S_CLEAR;
        endcase
    end

    // memory port control
    always_comb begin
        l1_we = 1'b0;
        l2_we = 1'b0;
        l1_wa = tlc_pkg::l1_set(r_addr);
        l2_wa = tlc_pkg::l2_set(r_addr);
        l1_wd = l1_res.row;
        l2_wd = l2_res.row;
        l1_ra = tlc_pkg::l1_set(i_address);
        l2_ra = tlc_pkg::l2_set(i_address);
        case (r_state)
            tlc_pkg::S_CLEAR: begin
                l1_we = 1'b1;
                l2_we = 1'b1;
                l1_wa = r_clr[tlc_pkg::L1_SET_W-1:0];
                l2_wa = r_clr[tlc_pkg::L2_SET_W-1:0];
                l1_wd = '0;
                l2_wd = '0;
            end
            tlc_pkg::S_LOOKUP: begin
                l1_we = 1'b1;
                l2_we = !l1_res.hit;
            end
            tlc_pkg::S_FIX_RD: begin
                l1_ra = tlc_pkg::l1_set(r_v2);
                l2_ra = tlc_pkg::l2_set(r_v1);
            end
            tlc_pkg::S_FIX: begin
                l1_we = r_need_drop;
                l2_we = r_need_touch;
                l1_wa = tlc_pkg::l1_set(r_v2);
                l2_wa = tlc_pkg::l2_set(r_v1);
                l1_wd = tlc_pkg::l1_drop(r_l1_rd, tlc_pkg::l1_tag(r_v2));
                l2_wd = tlc_pkg::l2_touch(r_l2_rd, tlc_pkg::l2_tag(r_v1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (l1_we)
            r_l1_mem[l1_wa] <= l1_wd;
        r_l1_rd <= r_l1_mem[l1_ra];
    end

    always_ff @(posedge i_clk) begin
        if (l2_we)
            r_l2_mem[l2_wa] <= l2_wd;
        r_l2_rd <= r_l2_mem[l2_ra];
    end

    // payload of the item in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_addr <= i_address;
        end
        if (r_state == tlc_pkg::S_LOOKUP) begin
            r_l1_hit     <= l1_res.hit;
            r_l2_hit     <= !l1_res.hit && l2_res.hit;
            r_need_drop  <= !l1_res.hit && !l2_res.hit && l2_res.removed;
            r_need_touch <= !l1_res.hit && l1_res.wback;
            r_v1         <= l1_res.vaddr;
            r_v2         <= l2_res.vaddr;
        end
        if (load) begin
            r_o_l1_hit <= r_l1_hit;
            r_o_looked <= !r_l1_hit;
            r_o_l2_hit <= r_l2_hit;
            r_o_cyc    <= cyc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlc_pkg::S_CLEAR;
            r_clr       <= '0;
            r_o_vld     <= 1'b0;
            r_l1_acc    <= '0;
            r_l1_miss   <= '0;
            r_l2_acc    <= '0;
            r_l2_miss   <= '0;
            r_cyc_sum   <= '0;
            r_l1_walloc <= 1'b1;
            r_l2_walloc <= 1'b1;
            r_l1_lat    <= 10'd1;
            r_l2_lat    <= 10'd10;
            r_mem_lat   <= 10'd100;
        end else begin
            r_state <= n_state;
            if (r_state == tlc_pkg::S_CLEAR)
                r_clr <= r_clr + 1'b1;
            if (load)
                r_o_vld <= 1'b1;
            else if (!i_stall)
                r_o_vld <= 1'b0;
            if (load) begin
                if (r_l1_acc != '1)
                    r_l1_acc <= r_l1_acc + 1'b1;
                if (!r_l1_hit) begin
                    if (r_l1_miss != '1)
                        r_l1_miss <= r_l1_miss + 1'b1;
                    if (r_l2_acc != '1)
                        r_l2_acc <= r_l2_acc + 1'b1;
                    if (!r_l2_hit && r_l2_miss != '1)
                        r_l2_miss <= r_l2_miss + 1'b1;
                end
                if (cyc_sum_wide[tlc_pkg::CYC_W])
                    r_cyc_sum <= '1;
                else
                    r_cyc_sum <= cyc_sum_wide[tlc_pkg::CYC_W-1:0];
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tlc_pkg::CFG_L1_WALLOC: r_l1_walloc <= i_cfg_data[0];
                    tlc_pkg::CFG_L2_WALLOC: r_l2_walloc <= i_cfg_data[0];
                    tlc_pkg::CFG_L1_LAT:    r_l1_lat    <= i_cfg_data;
                    tlc_pkg::CFG_L2_LAT:    r_l2_lat    <= i_cfg_data;
                    tlc_pkg::CFG_MEM_LAT:   r_mem_lat   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_stall           = (r_state != tlc_pkg::S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_valid           = r_o_vld;
    assign o_l1_hit          = r_o_l1_hit;
    assign o_l2_looked_up    = r_o_looked;
    assign o_l2_hit          = r_o_l2_hit;
    assign o_access_cycles   = r_o_cyc;
    assign o_l1_access_count = r_l1_acc;
    assign o_l1_miss_count   = r_l1_miss;
    assign o_l2_access_count = r_l2_acc;
    assign o_l2_miss_count   = r_l2_miss;
    assign o_cycle_total     = r_cyc_sum;

endmodule
